@@ src/fchc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchc_pkg
// Shared constants and types for the fan curve controller: register map,
// reset values, field widths and the interpolation request record.
// ----------------------------------------------------------------------------
package fchc_pkg;

    localparam int TEMP_W  = 16;
    localparam int DUTY_W  = 7;
    localparam int SPAN_W  = TEMP_W + 1;
    localparam int ACC_W   = 24;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    localparam logic [CFG_A_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_MODE       = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_TURN_ON    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_TURN_OFF   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_CURVE_LO_T = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_CURVE_HI_T = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_LOW_DUTY   = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_HIGH_DUTY  = 3'd7;

    localparam logic signed [TEMP_W-1:0] RST_TURN_ON    = 16'sd800;
    localparam logic signed [TEMP_W-1:0] RST_TURN_OFF   = 16'sd720;
    localparam logic signed [TEMP_W-1:0] RST_CURVE_LO_T = 16'sd640;
    localparam logic signed [TEMP_W-1:0] RST_CURVE_HI_T = 16'sd1120;
    localparam logic [DUTY_W-1:0]        RST_LOW_DUTY   = 7'd0;
    localparam logic [DUTY_W-1:0]        RST_HIGH_DUTY  = 7'd100;

    localparam logic MODE_ONOFF  = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0] off;
        logic [SPAN_W-1:0] span;
        logic [DUTY_W-1:0] dd;
    } t_interp_req;

endpackage

@@ src/fan_curve_hysteresis_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_curve_hysteresis_controller
// Fan control from temperature samples: on-off hysteresis or a linear duty
// curve; a result transaction only when the fan flag or duty changes.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[15:0] temperature
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata[0] fan_on, [7:1] duty
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One sample at a time: IDLE, EVAL when disabled or on-off; linear adds CHK
// outside the span and CALC then CHK inside it (serial multiply and divide
// in fchc_interp); a result adds EMIT, which waits for a free output slot.
// Synchronous active-low reset restores the register defaults, fan off.
// A result waiting on m_axis holds the next result in EMIT until taken;
// s_axis_tready is high only while no sample is in work.
// ----------------------------------------------------------------------------
module fan_curve_hysteresis_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] temperature
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [0] fan_on, [7:1] duty_percent
    input  logic                          i_cfg_we,
    input  logic [fchc_pkg::CFG_A_W-1:0]  i_cfg_idx,
    input  logic [fchc_pkg::CFG_D_W-1:0]  i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int TW = fchc_pkg::TEMP_W;
    localparam int DW = fchc_pkg::DUTY_W;

    logic                   r_enable;
    logic                   r_mode;
    logic signed [TW-1:0]   r_on_t;
    logic signed [TW-1:0]   r_off_t;
    logic signed [TW-1:0]   r_clo_t;
    logic signed [TW-1:0]   r_chi_t;
    logic [DW-1:0]          r_lo_d;
    logic [DW-1:0]          r_hi_d;

    logic                   r_fan_running;
    logic [DW-1:0]          r_cur_duty;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic signed [TW-1:0]   r_temp;
    logic [DW-1:0]          r_new_duty;
    logic                   r_new_fan;
    logic                   r_upd_fan;
    logic [DW-1:0]          r_base;

    logic                   r_m_tvalid;
    logic [7:0]             r_m_tdata;

    logic signed [TW-1:0]   n_hy_hi;
    logic signed [TW-1:0]   n_hy_lo;
    logic                   n_want;
    logic signed [TW-1:0]   n_c_lo;
    logic signed [TW-1:0]   n_c_hi;
    logic [DW-1:0]          n_d_min;
    logic [DW-1:0]          n_d_max;
    logic [DW-1:0]          n_lo_sat;
    logic [DW-1:0]          n_hi_sat;
    logic signed [TW:0]     n_span;
    logic signed [TW:0]     n_off;
    logic                   n_below;
    logic                   n_above;
    logic                   n_start;
    logic                   n_slot;
    fchc_pkg::t_interp_req  n_req;
    logic                   w_done;
    logic [DW-1:0]          w_quot;

    always_comb begin
        n_hy_hi  = (r_on_t > r_off_t) ? r_on_t : r_off_t;
        n_hy_lo  = (r_on_t > r_off_t) ? r_off_t : r_on_t;
        n_want   = r_fan_running ? (r_temp > n_hy_lo) : (r_temp > n_hy_hi);
        n_c_lo   = (r_clo_t < r_chi_t) ? r_clo_t : r_chi_t;
        n_c_hi   = (r_clo_t < r_chi_t) ? r_chi_t : r_clo_t;
        n_d_min  = (r_lo_d < r_hi_d) ? r_lo_d : r_hi_d;
        n_d_max  = (r_lo_d < r_hi_d) ? r_hi_d : r_lo_d;
        n_lo_sat = (n_d_min > fchc_pkg::DUTY_FULL) ? fchc_pkg::DUTY_FULL : n_d_min;
        n_hi_sat = (n_d_max > fchc_pkg::DUTY_FULL) ? fchc_pkg::DUTY_FULL : n_d_max;
        n_below  = (r_temp <= n_c_lo);
        n_above  = (r_temp >= n_c_hi);
        n_span   = {n_c_hi[TW-1], n_c_hi} - {n_c_lo[TW-1], n_c_lo};
        n_off    = {r_temp[TW-1], r_temp} - {n_c_lo[TW-1], n_c_lo};
        n_req.off  = n_off[TW-1:0];
        n_req.span = n_span[TW:0];
        n_req.dd   = n_hi_sat - n_lo_sat;
        n_start  = (r_state == ST_EVAL) && r_enable && (r_mode == fchc_pkg::MODE_LINEAR)
                   && !n_below && !n_above;
        n_slot   = !r_m_tvalid || m_axis_tready;
    end

    fchc_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_req   (n_req),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!r_enable) begin
                    n_state = ST_IDLE;
                end else if (r_mode == fchc_pkg::MODE_ONOFF) begin
                    n_state = (n_want != r_fan_running) ? ST_EMIT : ST_IDLE;
                end else if (n_below || n_above) begin
                    n_state = ST_CHK;
                end else begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_state = (r_new_duty != r_cur_duty) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (n_slot) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath of the sample in work
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_temp <= s_axis_tdata;
            end
            ST_EVAL: begin
                r_base <= n_lo_sat;
                if (r_mode == fchc_pkg::MODE_ONOFF) begin
                    r_upd_fan  <= 1'b1;
                    r_new_fan  <= n_want;
                    r_new_duty <= n_want ? fchc_pkg::DUTY_FULL : '0;
                end else begin
                    r_upd_fan  <= 1'b0;
                    r_new_duty <= n_below ? n_lo_sat : n_hi_sat;
                end
            end
            ST_CALC: begin
                if (w_done) begin
                    r_new_duty <= r_base + w_quot;
                end
            end
            ST_CHK: begin
                r_new_fan <= (r_new_duty != '0);
            end
            default: ;
        endcase
    end

    // configuration registers and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_mode        <= fchc_pkg::MODE_ONOFF;
            r_on_t        <= fchc_pkg::RST_TURN_ON;
            r_off_t       <= fchc_pkg::RST_TURN_OFF;
            r_clo_t       <= fchc_pkg::RST_CURVE_LO_T;
            r_chi_t       <= fchc_pkg::RST_CURVE_HI_T;
            r_lo_d        <= fchc_pkg::RST_LOW_DUTY;
            r_hi_d        <= fchc_pkg::RST_HIGH_DUTY;
            r_fan_running <= 1'b0;
            r_cur_duty    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fchc_pkg::REG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_fan_running <= 1'b0;
                            r_cur_duty    <= '0;
                        end
                    end
                    fchc_pkg::REG_MODE:       r_mode  <= i_cfg_data[0];
                    fchc_pkg::REG_TURN_ON:    r_on_t  <= i_cfg_data;
                    fchc_pkg::REG_TURN_OFF:   r_off_t <= i_cfg_data;
                    fchc_pkg::REG_CURVE_LO_T: r_clo_t <= i_cfg_data;
                    fchc_pkg::REG_CURVE_HI_T: r_chi_t <= i_cfg_data;
                    fchc_pkg::REG_LOW_DUTY:   r_lo_d  <= i_cfg_data[DW-1:0];
                    fchc_pkg::REG_HIGH_DUTY:  r_hi_d  <= i_cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if ((r_state == ST_EMIT) && n_slot) begin
                r_cur_duty <= r_new_duty;
                if (r_upd_fan) begin
                    r_fan_running <= r_new_fan;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == ST_EMIT) && n_slot) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && n_slot) begin
            r_m_tdata <= {r_new_duty, r_new_fan};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

@@ src/fchc_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchc_interp
// Serial interpolation unit: floor((2*off*dd + span) / (2*span)).
// Shift-and-add multiply, one multiplier bit per cycle, then restoring
// division, one quotient bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module fchc_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  fchc_pkg::t_interp_req       i_req,
    output logic                        o_done,
    output logic [fchc_pkg::DUTY_W-1:0] o_quot
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [2:0] LAST    = 3'(fchc_pkg::DUTY_W - 1);

    logic [1:0]                        r_phase;
    logic [2:0]                        r_cnt;
    logic                              r_done;
    logic [fchc_pkg::ACC_W-1:0]        r_acc;
    logic [fchc_pkg::ACC_W-1:0]        r_mcand;
    logic [fchc_pkg::DUTY_W-1:0]       r_mplier;
    logic [fchc_pkg::ACC_W-1:0]        r_div;
    logic [fchc_pkg::DUTY_W-1:0]       r_quot;
    logic                              n_qbit;

    assign n_qbit = (r_acc >= r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                        r_cnt   <= '0;
                    end
                end
                PH_MUL: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == LAST) begin
                        r_phase <= PH_DIV;
                        r_cnt   <= '0;
                    end
                end
                PH_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == LAST) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_acc    <= fchc_pkg::ACC_W'(i_req.span);
                    r_mcand  <= fchc_pkg::ACC_W'({i_req.off, 1'b0});
                    r_mplier <= i_req.dd;
                    r_div    <= fchc_pkg::ACC_W'({i_req.span, 7'b0});
                    r_quot   <= '0;
                end
            end
            PH_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[fchc_pkg::ACC_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[fchc_pkg::DUTY_W-1:1]};
            end
            PH_DIV: begin
                if (n_qbit) begin
                    r_acc <= r_acc - r_div;
                end
                r_quot <= {r_quot[fchc_pkg::DUTY_W-2:0], n_qbit};
                r_div  <= {1'b0, r_div[fchc_pkg::ACC_W-1:1]};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ tb/tb_fan_curve_hysteresis_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fan_curve_hysteresis_controller
// Self-checking bench for the fan curve controller. Temperature samples are
// streamed in with random gaps and results are drained with random stalls.
// A behavioral model of the hysteresis and the interpolated duty curve
// predicts each fan update, and every result is checked field by field.
// Registers change only while the block is idle, between setups.
// ----------------------------------------------------------------------------
module tb_fan_curve_hysteresis_controller;

    localparam int HALF_PERIOD    = 5;
    localparam int MAX_WAIT       = 17;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_SAMPLES = 2000;

    typedef struct packed {
        logic                        fan_on;
        logic [fchc_pkg::DUTY_W-1:0] duty;
    } t_fan_update;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata  = '0;   // [15:0] temperature
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b1;
    logic [7:0]                     m_axis_tdata;         // [0] fan_on, [7:1] duty_percent
    logic                           i_cfg_we      = 1'b0;
    logic [fchc_pkg::CFG_A_W-1:0]   i_cfg_idx     = '0;
    logic [fchc_pkg::CFG_D_W-1:0]   i_cfg_data    = '0;

    // model copy of registers and state
    logic                               cfg_en;
    logic                               cfg_mode;
    logic signed [fchc_pkg::TEMP_W-1:0] thr_on;
    logic signed [fchc_pkg::TEMP_W-1:0] thr_off;
    logic signed [fchc_pkg::TEMP_W-1:0] crv_lo_t;
    logic signed [fchc_pkg::TEMP_W-1:0] crv_hi_t;
    logic [fchc_pkg::DUTY_W-1:0]        duty_lo_reg;
    logic [fchc_pkg::DUTY_W-1:0]        duty_hi_reg;
    logic                               fan_running;
    logic [fchc_pkg::DUTY_W-1:0]        cur_duty;

    logic [15:0] temp_queue[$];
    t_fan_update fan_updates_due[$];

    int  n_pushed   = 0;
    int  n_enabled  = 0;
    int  n_taken    = 0;
    int  n_results  = 0;
    int  n_writes   = 0;
    int  n_setups   = 0;
    int  n_errors   = 0;
    int  quiet      = 0;
    int  gap_left   = 0;
    int  rdy_hold   = 0;
    bit  throttle   = 1'b1;
    logic s_fire    = 1'b0;
    logic m_fire    = 1'b0;

    fan_curve_hysteresis_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int gap_draw();
        return throttle ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    function automatic logic signed [fchc_pkg::TEMP_W-1:0] clamp16(input int v);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return fchc_pkg::TEMP_W'(v);
    endfunction

    function automatic logic [fchc_pkg::DUTY_W-1:0] curve_lookup(input int t);
        int a, b, lo_t, hi_t, da, db, lo_d, hi_d;
        longint span, off, d;
        a = crv_lo_t;
        b = crv_hi_t;
        lo_t = a < b ? a : b;
        hi_t = a < b ? b : a;
        da = duty_lo_reg;
        db = duty_hi_reg;
        lo_d = da < db ? da : db;
        hi_d = da < db ? db : da;
        if (lo_d > fchc_pkg::DUTY_FULL) lo_d = fchc_pkg::DUTY_FULL;
        if (hi_d > fchc_pkg::DUTY_FULL) hi_d = fchc_pkg::DUTY_FULL;
        if (t <= lo_t) return fchc_pkg::DUTY_W'(lo_d);
        if (t >= hi_t) return fchc_pkg::DUTY_W'(hi_d);
        span = longint'(hi_t) - lo_t;
        off  = longint'(t) - lo_t;
        d = lo_d + (2 * off * (hi_d - lo_d) + span) / (2 * span);
        if (d < lo_d) d = lo_d;
        if (d > hi_d) d = hi_d;
        return fchc_pkg::DUTY_W'(d);
    endfunction

    // advances the model by one sample; returns 1 when a fan update is due
    function automatic bit step_fan_model(input logic signed [fchc_pkg::TEMP_W-1:0] temp,
                                          output t_fan_update upd);
        int t, a, b, hi, lo;
        logic want;
        logic [fchc_pkg::DUTY_W-1:0] d;
        t = temp;
        upd = '0;
        if (!cfg_en) return 1'b0;
        if (cfg_mode == fchc_pkg::MODE_ONOFF) begin
            a = thr_on;
            b = thr_off;
            hi = a > b ? a : b;
            lo = a > b ? b : a;
            want = fan_running ? (t > lo) : (t > hi);
            if (want == fan_running) return 1'b0;
            fan_running = want;
            cur_duty = want ? fchc_pkg::DUTY_FULL : '0;
            upd.fan_on = want;
            upd.duty = cur_duty;
            return 1'b1;
        end
        d = curve_lookup(t);
        if (d == cur_duty) return 1'b0;
        cur_duty = d;
        upd.fan_on = (d != '0);
        upd.duty = d;
        return 1'b1;
    endfunction

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end else if (temp_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= temp_queue.pop_front();
                gap_left = gap_draw();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(negedge i_clk) begin
        if (m_fire) begin
            rdy_hold = gap_draw();
        end else if (rdy_hold == 0 && $urandom_range(0, 7) == 0) begin
            rdy_hold = gap_draw();
        end
        if (rdy_hold > 0) begin
            m_axis_tready <= 1'b0;
            rdy_hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin : monitor
        t_fan_update upd, got, want;
        if (!i_rst_n) begin
            s_fire <= 1'b0;
            m_fire <= 1'b0;
            quiet  <= 0;
        end else begin
            s_fire <= s_axis_tvalid && s_axis_tready;
            m_fire <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                n_taken++;
                if (step_fan_model(s_axis_tdata, upd)) fan_updates_due.push_back(upd);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got.fan_on = m_axis_tdata[0];
                got.duty   = m_axis_tdata[7:1];
                if (fan_updates_due.size() == 0) begin
                    $error("unexpected result transaction: fan_on %0d duty_percent %0d",
                           got.fan_on, got.duty);
                    n_errors++;
                end else begin
                    want = fan_updates_due.pop_front();
                    if (got.fan_on !== want.fan_on) begin
                        $error("fan_on: expected %0d, got %0d", want.fan_on, got.fan_on);
                        n_errors++;
                    end
                    if (got.duty !== want.duty) begin
                        $error("duty_percent: expected %0d, got %0d", want.duty, got.duty);
                        n_errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, fan_updates_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_temp(input int t);
        temp_queue.push_back(clamp16(t));
        n_pushed++;
        if (cfg_en) n_enabled++;
    endtask

    // wait until every sample is taken and every update has come back
    task automatic settle();
        while (n_pushed != n_taken || fan_updates_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [fchc_pkg::CFG_A_W-1:0] idx,
                             input logic [fchc_pkg::CFG_D_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        n_writes++;
        case (idx)
            fchc_pkg::REG_ENABLE: begin
                cfg_en = data[0];
                if (!data[0]) begin
                    fan_running = 1'b0;
                    cur_duty = '0;
                end
            end
            fchc_pkg::REG_MODE:       cfg_mode = data[0];
            fchc_pkg::REG_TURN_ON:    thr_on = data;
            fchc_pkg::REG_TURN_OFF:   thr_off = data;
            fchc_pkg::REG_CURVE_LO_T: crv_lo_t = data;
            fchc_pkg::REG_CURVE_HI_T: crv_hi_t = data;
            fchc_pkg::REG_LOW_DUTY:   duty_lo_reg = data[fchc_pkg::DUTY_W-1:0];
            fchc_pkg::REG_HIGH_DUTY:  duty_hi_reg = data[fchc_pkg::DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // a band of temperatures, full range or a narrow random window
    task automatic make_pair(input bit extreme, output int lo_v, output int hi_v);
        if (extreme) begin
            lo_v = -32768;
            hi_v = 32767;
        end else begin
            lo_v = int'($urandom_range(0, 65535)) - 32768;
            hi_v = clamp16(lo_v + int'($urandom_range(0, 300)));
        end
    endtask

    function automatic int temp_near(input int lo, input int hi);
        if ($urandom_range(0, 6) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return lo - 64 + int'($urandom_range(0, hi - lo + 128));
    endfunction

    function automatic logic [fchc_pkg::CFG_D_W-1:0] duty_word(input int d);
        logic [fchc_pkg::CFG_D_W-fchc_pkg::DUTY_W-1:0] upper;
        upper = ($urandom_range(0, 3) == 0) ?
                (fchc_pkg::CFG_D_W-fchc_pkg::DUTY_W)'($urandom) : '0;
        return {upper, fchc_pkg::DUTY_W'(d)};
    endfunction

    task automatic random_setup();
        int kind, p_lo, p_hi, c_lo, c_hi, dl, dh, n;
        kind = $urandom_range(0, 9);
        throttle = ($urandom_range(0, 3) != 0);
        n_setups++;
        if ($urandom_range(0, 3) == 0) cfg_write(fchc_pkg::REG_ENABLE, 16'd0);
        make_pair(kind == 0, p_lo, p_hi);
        make_pair(kind == 1, c_lo, c_hi);
        if ($urandom_range(0, 1)) begin
            cfg_write(fchc_pkg::REG_TURN_ON, 16'(p_hi));
            cfg_write(fchc_pkg::REG_TURN_OFF, 16'(p_lo));
        end else begin
            cfg_write(fchc_pkg::REG_TURN_ON, 16'(p_lo));
            cfg_write(fchc_pkg::REG_TURN_OFF, 16'(p_hi));
        end
        if ($urandom_range(0, 1)) begin
            cfg_write(fchc_pkg::REG_CURVE_LO_T, 16'(c_lo));
            cfg_write(fchc_pkg::REG_CURVE_HI_T, 16'(c_hi));
        end else begin
            cfg_write(fchc_pkg::REG_CURVE_LO_T, 16'(c_hi));
            cfg_write(fchc_pkg::REG_CURVE_HI_T, 16'(c_lo));
        end
        dl = $urandom_range(0, 127);
        dh = $urandom_range(0, 127);
        if (kind == 2) begin
            dl = 0;
            dh = 127;
        end else if (kind == 3) begin
            dl = 100;
            dh = 0;
        end
        cfg_write(fchc_pkg::REG_LOW_DUTY, duty_word(dl));
        cfg_write(fchc_pkg::REG_HIGH_DUTY, duty_word(dh));
        cfg_write(fchc_pkg::REG_MODE, $urandom_range(0, 1) ?
                  {15'd0, fchc_pkg::MODE_LINEAR} : {15'd0, fchc_pkg::MODE_ONOFF});
        cfg_write(fchc_pkg::REG_ENABLE, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0);
        cfg_release();
        n = $urandom_range(60, 140);
        repeat (n) begin
            if (cfg_mode == fchc_pkg::MODE_ONOFF) push_temp(temp_near(p_lo, p_hi));
            else push_temp(temp_near(c_lo, c_hi));
        end
        settle();
    endtask

    initial begin
        cfg_en      = 1'b0;
        cfg_mode    = fchc_pkg::MODE_ONOFF;
        thr_on      = fchc_pkg::RST_TURN_ON;
        thr_off     = fchc_pkg::RST_TURN_OFF;
        crv_lo_t    = fchc_pkg::RST_CURVE_LO_T;
        crv_hi_t    = fchc_pkg::RST_CURVE_HI_T;
        duty_lo_reg = fchc_pkg::RST_LOW_DUTY;
        duty_hi_reg = fchc_pkg::RST_HIGH_DUTY;
        fan_running = 1'b0;
        cur_duty    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: samples ignored
        push_temp(900);
        push_temp(-5);
        settle();

        // hysteresis with reset thresholds, edges of the band and extremes
        cfg_write(fchc_pkg::REG_ENABLE, 16'd1);
        cfg_release();
        push_temp(800);
        push_temp(801);
        push_temp(721);
        push_temp(720);
        push_temp(32767);
        push_temp(-32768);
        settle();

        // thresholds written in reversed order
        cfg_write(fchc_pkg::REG_TURN_ON, 16'(-100));
        cfg_write(fchc_pkg::REG_TURN_OFF, 16'd100);
        cfg_release();
        push_temp(101);
        push_temp(-100);
        push_temp(101);
        settle();

        // disabling clears the running fan
        cfg_write(fchc_pkg::REG_ENABLE, 16'd0);
        cfg_write(fchc_pkg::REG_ENABLE, 16'd1);
        cfg_release();
        push_temp(101);
        settle();

        // linear curve with reset points; duty stays 0 just above the low point
        cfg_write(fchc_pkg::REG_MODE, {15'd0, fchc_pkg::MODE_LINEAR});
        cfg_release();
        push_temp(640);
        push_temp(641);
        push_temp(645);
        push_temp(880);
        push_temp(1120);
        push_temp(32767);
        push_temp(-32768);
        settle();

        // reversed points, reversed duties, duty register above full scale
        cfg_write(fchc_pkg::REG_CURVE_LO_T, 16'd1120);
        cfg_write(fchc_pkg::REG_CURVE_HI_T, 16'd640);
        cfg_write(fchc_pkg::REG_LOW_DUTY, 16'd127);
        cfg_write(fchc_pkg::REG_HIGH_DUTY, 16'd20);
        cfg_release();
        push_temp(0);
        push_temp(32767);
        push_temp(880);
        settle();

        // coincident curve points
        cfg_write(fchc_pkg::REG_CURVE_LO_T, 16'd500);
        cfg_write(fchc_pkg::REG_CURVE_HI_T, 16'd500);
        cfg_release();
        push_temp(500);
        push_temp(501);
        settle();

        // widest span
        cfg_write(fchc_pkg::REG_CURVE_LO_T, 16'h8000);
        cfg_write(fchc_pkg::REG_CURVE_HI_T, 16'h7fff);
        cfg_write(fchc_pkg::REG_LOW_DUTY, 16'd0);
        cfg_write(fchc_pkg::REG_HIGH_DUTY, 16'd100);
        cfg_release();
        push_temp(0);
        settle();

        while (n_pushed < RANDOM_SAMPLES) random_setup();

        $display("%0d samples sent, %0d while enabled; %0d fan updates checked",
                 n_pushed, n_enabled, n_results);
        $display("%0d register writes across %0d random setups in both modes",
                 n_writes, n_setups);
        if (n_errors == 0 && fan_updates_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
